// File: hw/rtl/vnfo_pkg.sv
// Shared types, constants and lookup functions for the fractal value noise block.
package vnfo_pkg;

    localparam logic [31:0] PHI_Q32   = 32'd2654435388;
    localparam logic [8:0]  PRIME_X   = 9'd173;
    localparam logic [8:0]  PRIME_Y   = 9'd263;
    localparam logic [8:0]  PRIME_Z   = 9'd337;
    localparam int          ADDR_W    = 13;
    localparam int          SUM_W     = 24;
    localparam int          OCT_W     = 5;

    // Configuration register indexes
    localparam logic [1:0] REG_OCTAVES = 2'd0;
    localparam logic [1:0] REG_LACUN   = 2'd1;
    localparam logic [1:0] REG_GAIN    = 2'd2;
    localparam logic [1:0] REG_TURB    = 2'd3;

    localparam logic OPC_EVAL  = 1'b0;
    localparam logic OPC_WRITE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic signed [31:0] z_coord;
        logic [8:0]         entry_index;
        logic [15:0]        entry_value;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] noise_value;
        logic               was_write;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_FRAC,
        OP_HASH,
        OP_BEND,
        OP_ADDR,
        OP_REDUCE,
        OP_READ,
        OP_CAPT,
        OP_LERP,
        OP_TERM,
        OP_SCALE,
        OP_AMP,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] idx;
        logic       accept;
    } dp_cmd_t;

    typedef struct packed {
        logic addr_big;
    } dp_status_t;

    function automatic logic [8:0] prime_of(input logic [1:0] dim);
        logic [8:0] p;
        unique case (dim)
            2'd0:    p = PRIME_X;
            2'd1:    p = PRIME_Y;
            default: p = PRIME_Z;
        endcase
        return p;
    endfunction

    // Lerp schedule: z pairs, then y pairs, then the x pair; result lands on source a
    function automatic logic [2:0] lerp_a(input logic [2:0] j);
        logic [2:0] r;
        unique case (j)
            3'd0:    r = 3'd0;
            3'd1:    r = 3'd2;
            3'd2:    r = 3'd4;
            3'd3:    r = 3'd6;
            3'd4:    r = 3'd0;
            3'd5:    r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] lerp_b(input logic [2:0] j);
        logic [2:0] r;
        unique case (j)
            3'd0:    r = 3'd1;
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd5;
            3'd3:    r = 3'd7;
            3'd4:    r = 3'd2;
            3'd5:    r = 3'd6;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] lerp_w(input logic [2:0] j);
        logic [1:0] r;
        unique case (j)
            3'd0, 3'd1, 3'd2, 3'd3: r = 2'd2;
            3'd4, 3'd5:             r = 2'd1;
            default:                r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/vnfo_dp.sv
// Datapath: shared multiplier, lattice table, hash/weight/corner registers, accumulator.
module vnfo_dp #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vnfo_pkg::dp_cmd_t    cmd,
    output vnfo_pkg::dp_status_t status,
    input  vnfo_pkg::in_item_t   req,
    input  logic [15:0]         lacunarity,
    input  logic [15:0]         gain,
    input  logic                turbulence_mode,
    output vnfo_pkg::out_item_t  rsp
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [vnfo_pkg::ADDR_W-1:0] DEPTH_A = vnfo_pkg::ADDR_W'(TABLE_DEPTH);

    logic [15:0]        mem [TABLE_DEPTH];
    logic [15:0]        rdata_reg;
    logic signed [31:0] p_reg [3];
    logic [31:0]        frac_reg;
    logic [8:0]         h_reg [6];
    logic [16:0]        w_reg [3];
    logic [15:0]        c_reg [8];
    logic [16:0]        amp_reg;
    logic signed [vnfo_pkg::SUM_W-1:0] sum_reg;
    logic               wr_reg;
    logic [vnfo_pkg::ADDR_W-1:0] addr_reg;
    logic signed [65:0] prod_reg;
    vnfo_pkg::dp_op_t   wb_op_reg;
    logic [2:0]         wb_idx_reg;
    vnfo_pkg::out_item_t rsp_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [31:0] pk;
    logic [31:0]        key;
    logic [15:0]        f_iss;
    logic [16:0]        g_iss;
    logic [15:0]        f_wb;
    logic signed [16:0] diff;
    logic signed [17:0] t_raw;
    logic signed [17:0] t_use;
    logic [15:0]        la_wb;
    logic signed [17:0] lerp_sum;
    logic signed [vnfo_pkg::SUM_W:0] res_wide;

    assign pk    = p_reg[cmd.idx[2:1]];
    assign key   = {{16{pk[31]}}, pk[31:16]} + {31'b0, cmd.idx[0]};
    assign f_iss = p_reg[cmd.idx[1:0]][15:0];
    assign g_iss = (f_iss > 16'd32768) ? (17'd65536 - {1'b0, f_iss}) : {1'b0, f_iss};
    assign diff  = $signed({1'b0, c_reg[vnfo_pkg::lerp_b(cmd.idx)]})
                 - $signed({1'b0, c_reg[vnfo_pkg::lerp_a(cmd.idx)]});
    assign t_raw = $signed({1'b0, c_reg[0], 1'b0}) - 18'sd65536;
    assign t_use = (turbulence_mode && t_raw[17]) ? -t_raw : t_raw;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            vnfo_pkg::OP_FRAC:
            begin
                mul_a = {1'b0, key};
                mul_b = {1'b0, vnfo_pkg::PHI_Q32};
            end
            vnfo_pkg::OP_HASH:
            begin
                mul_a = {1'b0, frac_reg};
                mul_b = {24'b0, vnfo_pkg::prime_of(cmd.idx[2:1])};
            end
            vnfo_pkg::OP_BEND:
            begin
                mul_a = {16'b0, g_iss};
                mul_b = {16'b0, g_iss};
            end
            vnfo_pkg::OP_LERP:
            begin
                mul_a = {{16{diff[16]}}, diff};
                mul_b = {16'b0, w_reg[vnfo_pkg::lerp_w(cmd.idx)]};
            end
            vnfo_pkg::OP_TERM:
            begin
                mul_a = {16'b0, amp_reg};
                mul_b = {{15{t_use[17]}}, t_use};
            end
            vnfo_pkg::OP_SCALE:
            begin
                mul_a = {p_reg[cmd.idx[1:0]][31], p_reg[cmd.idx[1:0]]};
                mul_b = {17'b0, lacunarity};
            end
            vnfo_pkg::OP_AMP:
            begin
                mul_a = {16'b0, amp_reg};
                mul_b = {17'b0, gain};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign f_wb     = p_reg[wb_idx_reg[1:0]][15:0];
    assign la_wb    = c_reg[vnfo_pkg::lerp_a(wb_idx_reg)];
    assign lerp_sum = $signed({2'b0, la_wb}) + prod_reg[33:16];
    assign res_wide = ($signed({sum_reg[vnfo_pkg::SUM_W-1], sum_reg})
                     + (vnfo_pkg::SUM_W+1)'(65536)) >>> 1;

    assign status.addr_big = (addr_reg >= DEPTH_A);
    assign rsp = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_op_reg  <= vnfo_pkg::OP_NONE;
            wb_idx_reg <= '0;
        end
        else
        begin
            wb_op_reg  <= cmd.op;
            wb_idx_reg <= cmd.idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && req.opcode == vnfo_pkg::OPC_WRITE
            && ({4'b0, req.entry_index} < DEPTH_A))
        begin
            mem[AW'({4'b0, req.entry_index})] <= req.entry_value;
        end
        if (cmd.op == vnfo_pkg::OP_READ)
        begin
            rdata_reg <= mem[addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (cmd.accept)
        begin
            p_reg[0] <= req.x_coord;
            p_reg[1] <= req.y_coord;
            p_reg[2] <= req.z_coord;
            amp_reg  <= 17'd65536;
            sum_reg  <= '0;
            wr_reg   <= req.opcode;
        end

        unique case (cmd.op)
            vnfo_pkg::OP_ADDR:
                addr_reg <= vnfo_pkg::ADDR_W'({4'b0, h_reg[{2'b0, cmd.idx[2]}]})
                          + vnfo_pkg::ADDR_W'({4'b0, h_reg[3'd2 + {2'b0, cmd.idx[1]}]})
                          + vnfo_pkg::ADDR_W'({4'b0, h_reg[3'd4 + {2'b0, cmd.idx[0]}]});
            vnfo_pkg::OP_REDUCE:
                addr_reg <= addr_reg - DEPTH_A;
            vnfo_pkg::OP_CAPT:
                c_reg[cmd.idx] <= rdata_reg;
            vnfo_pkg::OP_LOAD_OUT:
            begin
                rsp_reg.was_write   <= wr_reg;
                if (wr_reg)
                    rsp_reg.noise_value <= '0;
                else if (res_wide > 25'sd8388607)
                    rsp_reg.noise_value <= 24'sh7FFFFF;
                else if (res_wide < -25'sd8388608)
                    rsp_reg.noise_value <= 24'sh800000;
                else
                    rsp_reg.noise_value <= res_wide[23:0];
            end
            default:
            begin
            end
        endcase

        // Retire the product issued in the previous cycle
        unique case (wb_op_reg)
            vnfo_pkg::OP_FRAC:
                frac_reg <= prod_reg[31:0];
            vnfo_pkg::OP_HASH:
                h_reg[wb_idx_reg] <= prod_reg[40:32];
            vnfo_pkg::OP_BEND:
                w_reg[wb_idx_reg[1:0]] <= (f_wb > 16'd32768)
                                        ? (17'd65536 - prod_reg[31:15])
                                        : prod_reg[31:15];
            vnfo_pkg::OP_LERP:
                c_reg[vnfo_pkg::lerp_a(wb_idx_reg)] <= lerp_sum[15:0];
            vnfo_pkg::OP_TERM:
                sum_reg <= sum_reg + prod_reg[39:16];
            vnfo_pkg::OP_SCALE:
                p_reg[wb_idx_reg[1:0]] <= prod_reg[43:12];
            vnfo_pkg::OP_AMP:
                amp_reg <= prod_reg[32:16];
            default:
            begin
            end
        endcase
    end

endmodule

// File: hw/rtl/vnfo_ctrl.sv
// Controller: sequences hashing, bending, corner reads, lerps and accumulation per octave.
module vnfo_ctrl #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 req_opcode,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  logic [3:0]           octave_count,
    input  vnfo_pkg::dp_status_t  status,
    output vnfo_pkg::dp_cmd_t     cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_FRAC,
        S_HASH,
        S_BEND,
        S_ADDR,
        S_RED,
        S_CAPT,
        S_LERP,
        S_TERM,
        S_SCALE,
        S_AMP,
        S_DONE
    } state_t;

    localparam logic [vnfo_pkg::OCT_W-1:0] MAX_OCT = vnfo_pkg::OCT_W'(MAX_OCTAVES);

    state_t                     state_reg;
    logic [2:0]                 step_reg;
    logic                       ph_reg;
    logic [vnfo_pkg::OCT_W-1:0]  oct_reg;
    logic                       rsp_valid_reg;
    logic [vnfo_pkg::OCT_W-1:0]  oct_req;
    logic [vnfo_pkg::OCT_W-1:0]  oct_lim;
    logic                       accept;
    logic                       load_out;

    assign oct_req   = {1'b0, octave_count};
    assign oct_lim   = (oct_req > MAX_OCT) ? MAX_OCT : oct_req;
    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign load_out  = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd.accept = accept;
        cmd.idx    = step_reg;
        cmd.op     = vnfo_pkg::OP_NONE;
        unique case (state_reg)
            S_FRAC:  cmd.op = ph_reg ? vnfo_pkg::OP_NONE : vnfo_pkg::OP_FRAC;
            S_HASH:  cmd.op = ph_reg ? vnfo_pkg::OP_NONE : vnfo_pkg::OP_HASH;
            S_BEND:  cmd.op = ph_reg ? vnfo_pkg::OP_NONE : vnfo_pkg::OP_BEND;
            S_ADDR:  cmd.op = vnfo_pkg::OP_ADDR;
            S_RED:   cmd.op = status.addr_big ? vnfo_pkg::OP_REDUCE : vnfo_pkg::OP_READ;
            S_CAPT:  cmd.op = vnfo_pkg::OP_CAPT;
            S_LERP:  cmd.op = ph_reg ? vnfo_pkg::OP_NONE : vnfo_pkg::OP_LERP;
            S_TERM:  cmd.op = ph_reg ? vnfo_pkg::OP_NONE : vnfo_pkg::OP_TERM;
            S_SCALE: cmd.op = ph_reg ? vnfo_pkg::OP_NONE : vnfo_pkg::OP_SCALE;
            S_AMP:   cmd.op = ph_reg ? vnfo_pkg::OP_NONE : vnfo_pkg::OP_AMP;
            S_DONE:  cmd.op = load_out ? vnfo_pkg::OP_LOAD_OUT : vnfo_pkg::OP_NONE;
            default: cmd.op = vnfo_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            ph_reg        <= 1'b0;
            oct_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    ph_reg   <= 1'b0;
                    oct_reg  <= '0;
                    if (accept)
                    begin
                        if (req_opcode == vnfo_pkg::OPC_WRITE || oct_lim == '0)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_FRAC;
                    end
                end
                S_FRAC:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                        state_reg <= S_HASH;
                end
                S_HASH:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (step_reg == 3'd5)
                        begin
                            step_reg  <= '0;
                            state_reg <= S_BEND;
                        end
                        else
                        begin
                            step_reg  <= step_reg + 3'd1;
                            state_reg <= S_FRAC;
                        end
                    end
                end
                S_BEND:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (step_reg == 3'd2)
                        begin
                            step_reg  <= '0;
                            state_reg <= S_ADDR;
                        end
                        else
                            step_reg <= step_reg + 3'd1;
                    end
                end
                S_ADDR:
                    state_reg <= S_RED;
                S_RED:
                    if (!status.addr_big)
                        state_reg <= S_CAPT;
                S_CAPT:
                begin
                    if (step_reg == 3'd7)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_LERP;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 3'd1;
                        state_reg <= S_ADDR;
                    end
                end
                S_LERP:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (step_reg == 3'd6)
                        begin
                            step_reg  <= '0;
                            state_reg <= S_TERM;
                        end
                        else
                            step_reg <= step_reg + 3'd1;
                    end
                end
                S_TERM:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                        state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (step_reg == 3'd2)
                        begin
                            step_reg  <= '0;
                            state_reg <= S_AMP;
                        end
                        else
                            step_reg <= step_reg + 3'd1;
                    end
                end
                S_AMP:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        oct_reg <= oct_reg + 1'b1;
                        if (oct_reg + 1'b1 == oct_lim)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_FRAC;
                    end
                end
                S_DONE:
                    if (load_out)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hw/rtl/value_noise_fractal_octaves.sv
// A table write's result loads once the output register is free after its transfer; an
// evaluation's time depends on the octave count and on the corner address wraps (up to two
// per corner at depth 512). One shared multiplier (issue, then retire) and one table read
// per corner set the length of an octave. One item is in work at a time; the next transfer
// is taken in the cycle after the result loads, while it waits in the output register.
// Reset clears control and configuration (4 octaves, lacunarity 2.0, gain 0.5, fBm).
module value_noise_fractal_octaves #(
    parameter int TABLE_DEPTH = 512,
    parameter int MAX_OCTAVES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    // item channel
    input  logic                req_valid,
    output logic                req_ready,
    input  vnfo_pkg::in_item_t   req,
    // result channel
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output vnfo_pkg::out_item_t  rsp,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    logic [3:0]  octave_count_reg;
    logic [15:0] lacunarity_reg;
    logic [15:0] gain_reg;
    logic        turbulence_reg;
    logic        cfg_write;

    vnfo_pkg::dp_cmd_t    cmd;
    vnfo_pkg::dp_status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Register file: one word per register, index from the word address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= 4'd4;
            lacunarity_reg   <= 16'd8192;
            gain_reg         <= 16'd32768;
            turbulence_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                vnfo_pkg::REG_OCTAVES: octave_count_reg <= pwdata[3:0];
                vnfo_pkg::REG_LACUN:   lacunarity_reg   <= pwdata[15:0];
                vnfo_pkg::REG_GAIN:    gain_reg         <= pwdata[15:0];
                default:               turbulence_reg   <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            vnfo_pkg::REG_OCTAVES: prdata = {28'b0, octave_count_reg};
            vnfo_pkg::REG_LACUN:   prdata = {16'b0, lacunarity_reg};
            vnfo_pkg::REG_GAIN:    prdata = {16'b0, gain_reg};
            default:               prdata = {31'b0, turbulence_reg};
        endcase
    end

    // Sequencer: owns the handshakes and walks each octave step by step
    vnfo_ctrl #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_opcode   (req.opcode),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .octave_count (octave_count_reg),
        .status       (status),
        .cmd          (cmd)
    );

    // Datapath: lattice table, hashing, bending, trilinear blend and the octave sum
    vnfo_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .req             (req),
        .lacunarity      (lacunarity_reg),
        .gain            (gain_reg),
        .turbulence_mode (turbulence_reg),
        .rsp             (rsp)
    );

endmodule

// File: tb/sv/tb.sv
// Testbench for the fractal value noise block: directed and random transfers checked against a local predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 512;
    localparam int OCT_LIMIT = 8;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    vnfo_pkg::in_item_t  req;
    logic                rsp_valid;
    logic                rsp_ready;
    vnfo_pkg::out_item_t rsp;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    value_noise_fractal_octaves uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: its own copy of the lattice and the registers
    logic [15:0] lattice_copy [DEPTH];
    bit          lattice_known [DEPTH];
    logic [3:0]  octaves_cfg;
    logic [15:0] lacun_cfg;
    logic [15:0] gain_cfg;
    logic        turb_cfg;

    vnfo_pkg::out_item_t noise_expected [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("value_noise_fractal_octaves test failed");
        $finish;
    end

    function automatic logic [31:0] hash_coord(input logic [31:0] i, input logic [8:0] prime);
        logic [63:0] prod;
        logic [63:0] h;
        prod = 64'(i) * 64'(vnfo_pkg::PHI_Q32);
        h = 64'(prime) * 64'(prod[31:0]);
        return h[63:32];
    endfunction

    function automatic logic [31:0] bend_frac(input logic [15:0] f);
        logic [33:0] g;
        if (f > 16'd32768)
        begin
            g = 34'd65536 - 34'(f);
            return 32'd65536 - 32'((g * g) >> 15);
        end
        return 32'((34'(f) * 34'(f)) >> 15);
    endfunction

    function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] w);
        logic [63:0] s;
        s = 64'(a) * (64'd65536 - 64'(w)) + 64'(b) * 64'(w);
        return 32'(s >> 16);
    endfunction

    // Table index of one corner from three hashed coordinates
    function automatic int corner_index(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
        logic [33:0] s;
        s = 34'(a) + 34'(b) + 34'(c);
        return int'(s % DEPTH);
    endfunction

    function automatic logic [31:0] lattice_at(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c);
        return 32'(lattice_copy[corner_index(a, b, c)]);
    endfunction

    function automatic logic [31:0] octave_noise(input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input logic signed [31:0] z);
        logic [31:0] xi, yi, zi, xa, xb, ya, yb, za, zb, wx, wy, wz;
        logic [31:0] c00, c01, c10, c11;
        xi = 32'(x >>> 16);
        yi = 32'(y >>> 16);
        zi = 32'(z >>> 16);
        xa = hash_coord(xi, vnfo_pkg::PRIME_X);
        xb = hash_coord(xi + 32'd1, vnfo_pkg::PRIME_X);
        ya = hash_coord(yi, vnfo_pkg::PRIME_Y);
        yb = hash_coord(yi + 32'd1, vnfo_pkg::PRIME_Y);
        za = hash_coord(zi, vnfo_pkg::PRIME_Z);
        zb = hash_coord(zi + 32'd1, vnfo_pkg::PRIME_Z);
        wx = bend_frac(x[15:0]);
        wy = bend_frac(y[15:0]);
        wz = bend_frac(z[15:0]);
        c00 = blend(lattice_at(xa, ya, za), lattice_at(xa, ya, zb), wz);
        c01 = blend(lattice_at(xa, yb, za), lattice_at(xa, yb, zb), wz);
        c10 = blend(lattice_at(xb, ya, za), lattice_at(xb, ya, zb), wz);
        c11 = blend(lattice_at(xb, yb, za), lattice_at(xb, yb, zb), wz);
        return blend(blend(c00, c01, wy), blend(c10, c11, wy), wx);
    endfunction

    function automatic logic signed [31:0] scale_coord(input logic signed [31:0] p);
        logic signed [63:0] s;
        s = (64'(p) * $signed({48'd0, lacun_cfg})) >>> 12;
        return s[31:0];
    endfunction

    function automatic vnfo_pkg::out_item_t predict_noise(input vnfo_pkg::in_item_t it);
        vnfo_pkg::out_item_t r;
        logic signed [31:0] x, y, z;
        longint amp, total, t, res;
        int n;
        r.was_write = 1'b0;
        x = it.x_coord;
        y = it.y_coord;
        z = it.z_coord;
        n = (octaves_cfg > OCT_LIMIT) ? OCT_LIMIT : octaves_cfg;
        amp = 65536;
        total = 0;
        for (int k = 0; k < n; k++)
        begin
            t = 2 * longint'(octave_noise(x, y, z)) - 65536;
            if (turb_cfg && t < 0)
                t = -t;
            total += (amp * t) >>> 16;
            x = scale_coord(x);
            y = scale_coord(y);
            z = scale_coord(z);
            amp = (amp * longint'(gain_cfg)) >>> 16;
        end
        res = (total + 65536) >>> 1;
        if (res > 8388607)
            res = 8388607;
        if (res < -8388608)
            res = -8388608;
        r.noise_value = res[23:0];
        return r;
    endfunction

    // True when every corner an evaluation could touch has been written
    function automatic bit point_covered(input vnfo_pkg::in_item_t it);
        logic signed [31:0] x, y, z;
        logic [31:0] xh [2], yh [2], zh [2];
        int n;
        x = it.x_coord;
        y = it.y_coord;
        z = it.z_coord;
        n = (octaves_cfg > OCT_LIMIT) ? OCT_LIMIT : octaves_cfg;
        for (int k = 0; k < n; k++)
        begin
            for (int d = 0; d < 2; d++)
            begin
                xh[d] = hash_coord(32'(x >>> 16) + 32'(d), vnfo_pkg::PRIME_X);
                yh[d] = hash_coord(32'(y >>> 16) + 32'(d), vnfo_pkg::PRIME_Y);
                zh[d] = hash_coord(32'(z >>> 16) + 32'(d), vnfo_pkg::PRIME_Z);
            end
            for (int c = 0; c < 8; c++)
                if (!lattice_known[corner_index(xh[c[2]], yh[c[1]], zh[c[0]])])
                    return 1'b0;
            x = scale_coord(x);
            y = scale_coord(y);
            z = scale_coord(z);
        end
        return 1'b1;
    endfunction

    // Send one item: idle at random, hold valid until the transfer, then predict
    task automatic send_item(input vnfo_pkg::in_item_t it);
        vnfo_pkg::out_item_t e;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        if (it.opcode == vnfo_pkg::OPC_WRITE)
        begin
            e.noise_value = '0;
            e.was_write   = 1'b1;
            lattice_copy[it.entry_index]  = it.entry_value;
            lattice_known[it.entry_index] = 1'b1;
        end
        else
            e = predict_noise(it);
        noise_expected.push_back(e);
    endtask

    task automatic send_write(input int idx, input logic [15:0] val);
        vnfo_pkg::in_item_t it;
        it = '0;
        it.opcode      = vnfo_pkg::OPC_WRITE;
        it.entry_index = 9'(idx);
        it.entry_value = val;
        send_item(it);
    endtask

    task automatic send_eval(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        vnfo_pkg::in_item_t it;
        it = '0;
        it.opcode  = vnfo_pkg::OPC_EVAL;
        it.x_coord = x;
        it.y_coord = y;
        it.z_coord = z;
        it.entry_index = 9'($urandom);
        it.entry_value = 16'($urandom);
        send_item(it);
    endtask

    // Drop valid, drain all results, then let the block settle before touching registers
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (noise_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        unique case (idx)
            vnfo_pkg::REG_OCTAVES: octaves_cfg = val[3:0];
            vnfo_pkg::REG_LACUN:   lacun_cfg   = val[15:0];
            vnfo_pkg::REG_GAIN:    gain_cfg    = val[15:0];
            default:               turb_cfg    = val[0];
        endcase
    endtask

    task automatic set_config(input int oct, input int lac, input int gn, input bit turb);
        wait_idle();
        write_reg(vnfo_pkg::REG_OCTAVES, 32'(oct));
        write_reg(vnfo_pkg::REG_LACUN, 32'(lac));
        write_reg(vnfo_pkg::REG_GAIN, 32'(gn));
        write_reg(vnfo_pkg::REG_TURB, 32'(turb));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random point: mostly small, sometimes full range, so every bit toggles
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(3) == 0)
            return $urandom;
        return 32'($signed($urandom_range(2097152)) - 1048576);
    endfunction

    task automatic fill_table();
        for (int i = 0; i < DEPTH; i++)
            send_write(i, 16'($urandom));
    endtask

    task automatic test_directed();
        send_write(0, 16'h0000);
        send_write(511, 16'hffff);
        fill_table();
        send_write(3, 16'hffff);
        send_write(4, 16'h0000);
        send_eval(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_eval(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_eval(32'hffff_ffff, 32'h0000_8000, 32'h0000_8001);
        send_eval(32'h0001_7fff, 32'hfffe_8000, 32'h1234_5678);
        send_eval(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_f0f0);
    endtask

    task automatic test_config_extremes();
        // octave count zero gives one half; oversized counts saturate
        set_config(0, 8192, 32768, 1'b0);
        send_eval(rand_coord(), rand_coord(), rand_coord());
        set_config(15, 65535, 65535, 1'b1);
        send_eval(rand_coord(), rand_coord(), rand_coord());
        send_eval(32'h7fff_ffff, 32'h8000_0000, 32'h0000_ffff);
        set_config(8, 0, 0, 1'b0);
        send_eval(rand_coord(), rand_coord(), rand_coord());
        set_config(1, 4096, 65535, 1'b1);
        send_eval(rand_coord(), rand_coord(), rand_coord());
        set_config(9, 12288, 65535, 1'b0);
        send_eval(rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic random_burst(input int count);
        vnfo_pkg::in_item_t it;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                it = '0;
                it.opcode      = vnfo_pkg::OPC_WRITE;
                it.x_coord     = $urandom;
                it.y_coord     = $urandom;
                it.z_coord     = $urandom;
                it.entry_index = 9'($urandom);
                it.entry_value = 16'($urandom);
                send_item(it);
                sent++;
            end
            else
            begin
                it = '0;
                it.opcode  = vnfo_pkg::OPC_EVAL;
                it.x_coord = rand_coord();
                it.y_coord = rand_coord();
                it.z_coord = rand_coord();
                if (point_covered(it))
                begin
                    send_item(it);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random();
        int oct;
        for (int ph = 0; ph < 12; ph++)
        begin
            oct = (ph % 3 == 0) ? $urandom_range(15) : $urandom_range(3, 1);
            set_config(oct, $urandom_range(65535), $urandom_range(65535), 1'($urandom));
            unique case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            random_burst(75);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_back_pressure();
        set_config(1, 8192, 32768, 1'b0);
        hold_off_cycles = 400;
        random_burst(10);
    endtask

    // Receiver: random stalls, plus a long hold-off when requested
    initial
    begin
        rsp_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Checker: compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        vnfo_pkg::out_item_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (noise_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: noise %0d write %0b",
                             rsp.noise_value, rsp.was_write);
            end
            else
            begin
                e = noise_expected.pop_front();
                if (rsp.noise_value !== e.noise_value || rsp.was_write !== e.was_write)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: noise exp %0d got %0d, write exp %0b got %0b",
                                 e.noise_value, rsp.noise_value, e.was_write, rsp.was_write);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        octaves_cfg = 4'd4;
        lacun_cfg = 16'd8192;
        gain_cfg = 16'd32768;
        turb_cfg = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            lattice_copy[i] = '0;
            lattice_known[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_random();
        test_back_pressure();
        wait_idle();
        repeat (800) @(posedge clk);

        if (mismatches == 0 && noise_expected.size() == 0)
            $display("value_noise_fractal_octaves test passed");
        else
            $display("value_noise_fractal_octaves test failed");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/vnfo_pkg.sv
hw/rtl/vnfo_dp.sv
hw/rtl/vnfo_ctrl.sv
hw/rtl/value_noise_fractal_octaves.sv
tb/sv/tb.sv
